/* rtl/pdam_pkg.sv */
// ============================================================================
// pdam_pkg
// Shared types and constants of the PD attitude mixer datapath.
// ============================================================================
package pdam_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int ISQRT_STEPS  = 29;
  localparam int CW           = 40;  // CORDIC x/y width
  localparam int ZW           = 28;  // CORDIC angle accumulator width, Q.24

  localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

  // Elementary angles atan(2^-i) in Q.24 radians.
  localparam logic [23:0] ATAN_TAB [CORDIC_STEPS] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
    24'd524117,   24'd262123,  24'd131069,  24'd65536,   24'd32768,
    24'd16384,    24'd8192,    24'd4096,    24'd2048,    24'd1024,
    24'd512,      24'd256,     24'd128,     24'd64,      24'd32
  };

  // Configuration register indexes.
  localparam logic [7:0] REG_ROLL_GAIN  = 8'd0;
  localparam logic [7:0] REG_PITCH_GAIN = 8'd1;
  localparam logic [7:0] REG_RATE_GAIN  = 8'd2;
  localparam logic [7:0] REG_DEFL_LIMIT = 8'd3;

  // Fields that ride along with an item through the angle pipeline.
  typedef struct packed {
    logic [63:0]        ts;
    logic               armed;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic               est;
  } side_t;

  // Trig terms of the quaternion, Q.28.
  typedef struct packed {
    side_t              sd;
    logic signed [33:0] sinr;
    logic signed [33:0] cosr;
    logic signed [33:0] sinp;
    logic               sat_p;
    logic               sat_n;
  } qside_t;

  typedef struct packed {
    side_t sd;
    logic  sat_p;
    logic  sat_n;
  } aside_t;

  // Gains and the effective (non-negative) servo limit.
  typedef struct packed {
    logic signed [15:0] roll_gain;
    logic signed [15:0] pitch_gain;
    logic signed [15:0] rate_gain;
    logic signed [15:0] lim;
  } gains_t;

endpackage

/* rtl/pd_attitude_mixer.sv */
// Pipeline of 4 front, 29 square root, 22 CORDIC and 3 mixer stages; it takes
// one word per cycle while the output is not stalled.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stalled output holds every stage in place.
// Reset (rst_n low, synchronous) clears all valid bits and loads the gains
// with zero and the deflection limit with 16384.
// ============================================================================
// pd_attitude_mixer
// PD attitude controller with an X-type four-servo mixer.
// ============================================================================
module pd_attitude_mixer (
  input  logic          clk,
  input  logic          rst_n,
  // Input stream.
  input  logic          in_tvalid,
  output logic          in_tready,
  // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y, [63:48] quat_z,
  // [79:64] gyro_roll_rate, [95:80] gyro_pitch_rate, [96] armed_in,
  // [160:97] timestamp_in, [167:161] zero
  input  logic [167:0]  in_tdata,
  // [0] estimate_valid
  input  logic [0:0]    in_tuser,
  // Result stream.
  output logic          out_tvalid,
  input  logic          out_tready,
  // [63:0] timestamp_out, [64] armed_out, [65] command_valid,
  // [81:66] servo_a, [97:82] servo_b, [113:98] servo_c, [129:114] servo_d,
  // [135:130] zero
  output logic [135:0]  out_tdata,
  // Configuration write channel.
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import pdam_pkg::*;

  // Global advance: every stage moves when the output word is absent or taken.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Configuration registers. Writes are always accepted; unknown indexes
  // are dropped.
  logic signed [15:0] roll_gain_r, pitch_gain_r, rate_gain_r, limit_r;
  gains_t             gains;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_gain_r  <= '0;
      pitch_gain_r <= '0;
      rate_gain_r  <= '0;
      limit_r      <= 16'sd16384;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROLL_GAIN:  roll_gain_r  <= cfg_data;
        REG_PITCH_GAIN: pitch_gain_r <= cfg_data;
        REG_RATE_GAIN:  rate_gain_r  <= cfg_data;
        REG_DEFL_LIMIT: limit_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // A negative limit behaves as zero, which forces every servo to zero.
  always_comb begin
    gains.roll_gain  = roll_gain_r;
    gains.pitch_gain = pitch_gain_r;
    gains.rate_gain  = rate_gain_r;
    gains.lim        = limit_r[15] ? 16'sd0 : limit_r;
  end

  // Unpack the input word.
  side_t sd_in;
  always_comb begin
    sd_in.ts    = in_tdata[160:97];
    sd_in.armed = in_tdata[96];
    sd_in.gx    = in_tdata[79:64];
    sd_in.gy    = in_tdata[95:80];
    sd_in.est   = in_tuser[0];
  end

  // Front end: products, sin/cos terms and 1 - sinp^2 for the pitch cosine.
  logic        fr_vld;
  qside_t      fr_qs;
  logic [57:0] fr_n;

  pdam_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .quat_w  (in_tdata[15:0]),
    .quat_x  (in_tdata[31:16]),
    .quat_y  (in_tdata[47:32]),
    .quat_z  (in_tdata[63:48]),
    .sd_in   (sd_in),
    .out_vld (fr_vld),
    .qs_out  (fr_qs),
    .n_out   (fr_n)
  );

  // Square root gives the cosine of pitch; the roll terms ride along.
  logic        sq_vld;
  logic [28:0] sq_root;
  qside_t      sq_qs;

  pdam_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (fr_vld),
    .n_in    (fr_n),
    .qs_in   (fr_qs),
    .out_vld (sq_vld),
    .root    (sq_root),
    .qs_out  (sq_qs)
  );

  // Lane 0 is roll = atan2(sinr, cosr), lane 1 is pitch = atan2(sinp, cosp).
  logic signed [CW-1:0] cx [2];
  logic signed [CW-1:0] cy [2];
  aside_t               c_as;
  logic                 c_vld;
  logic signed [15:0]   c_angle [2];
  aside_t               c_as_out;

  assign cx[0] = CW'(sq_qs.cosr);
  assign cy[0] = CW'(sq_qs.sinr);
  assign cx[1] = CW'(sq_root);
  assign cy[1] = CW'(sq_qs.sinp);
  assign c_as  = '{sd: sq_qs.sd, sat_p: sq_qs.sat_p, sat_n: sq_qs.sat_n};

  pdam_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .x_in    (cx),
    .y_in    (cy),
    .as_in   (c_as),
    .out_vld (c_vld),
    .angle   (c_angle),
    .as_out  (c_as_out)
  );

  // PD terms and mixing; the last mixer stage is the output register.
  logic [63:0]        ts_out;
  logic               armed_out;
  logic signed [15:0] servo_a, servo_b, servo_c, servo_d;

  pdam_mixer u_mixer (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (c_vld),
    .roll      (c_angle[0]),
    .pitch     (c_angle[1]),
    .as_in     (c_as_out),
    .gains     (gains),
    .out_vld   (out_tvalid),
    .ts_out    (ts_out),
    .armed_out (armed_out),
    .servo_a   (servo_a),
    .servo_b   (servo_b),
    .servo_c   (servo_c),
    .servo_d   (servo_d)
  );

  // Every result carries command_valid set.
  assign out_tdata = {6'b000000, servo_d, servo_c, servo_b, servo_a,
                      1'b1, armed_out, ts_out};

`ifndef SYNTHESIS
  logic signed [16:0] lim17;
  assign lim17 = {1'b0, gains.lim};

  // Servo words a and c never leave the configured clamp window.
  a_servo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (17'(servo_a) <= lim17 && 17'(servo_a) >= -lim17 &&
                    17'(servo_c) <= lim17 && 17'(servo_c) >= -lim17))
    else $error("servo outside deflection limit");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A held output word freezes the pipeline, so nothing is taken at the input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while output stalled");
`endif

endmodule

/* rtl/pdam_front.sv */
// ============================================================================
// pdam_front
// Quaternion products, trig terms and the argument of the pitch square root.
// ============================================================================
module pdam_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [15:0]   quat_w,
  input  logic signed [15:0]   quat_x,
  input  logic signed [15:0]   quat_y,
  input  logic signed [15:0]   quat_z,
  input  pdam_pkg::side_t      sd_in,
  output logic                 out_vld,
  output pdam_pkg::qside_t     qs_out,
  output logic [57:0]          n_out
);
  import pdam_pkg::*;

  logic               vld_r [4];
  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wy_r, p_zx_r;
  side_t              sd1_r;
  qside_t             qs2_r, qs3_r, qs4_r;
  logic [55:0]        sq_r;
  logic [57:0]        n_r;

  logic signed [33:0] sinr_nxt, cosr_nxt, sinp_nxt;
  logic signed [28:0] s29;
  logic signed [57:0] sq_full;
  logic [57:0]        n_nxt;

  always_comb begin
    sinr_nxt = (34'(p_wx_r) + 34'(p_yz_r)) <<< 1;
    cosr_nxt = 34'sh10000000 - ((34'(p_xx_r) + 34'(p_yy_r)) <<< 1);
    sinp_nxt = (34'(p_wy_r) - 34'(p_zx_r)) <<< 1;
    s29      = qs2_r.sinp[28:0];
    sq_full  = s29 * s29;
    n_nxt    = (58'd1 << 56) - {2'b00, sq_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= quat_w * quat_x;
      p_yz_r <= quat_y * quat_z;
      p_xx_r <= quat_x * quat_x;
      p_yy_r <= quat_y * quat_y;
      p_wy_r <= quat_w * quat_y;
      p_zx_r <= quat_z * quat_x;
      sd1_r  <= sd_in;

      qs2_r.sd    <= sd1_r;
      qs2_r.sinr  <= sinr_nxt;
      qs2_r.cosr  <= cosr_nxt;
      qs2_r.sinp  <= sinp_nxt;
      qs2_r.sat_p <= 1'b0;
      qs2_r.sat_n <= 1'b0;

      qs3_r.sd    <= qs2_r.sd;
      qs3_r.sinr  <= qs2_r.sinr;
      qs3_r.cosr  <= qs2_r.cosr;
      qs3_r.sinp  <= qs2_r.sinp;
      qs3_r.sat_p <= qs2_r.sinp >= 34'sh10000000;
      qs3_r.sat_n <= qs2_r.sinp <= -34'sh10000000;
      sq_r        <= sq_full[55:0];

      qs4_r <= qs3_r;
      n_r   <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '{default: 1'b0};
    end else if (en) begin
      vld_r[0] <= in_vld;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
      vld_r[3] <= vld_r[2];
    end
  end

  assign out_vld = vld_r[3];
  assign qs_out  = qs4_r;
  assign n_out   = n_r;

endmodule

/* rtl/pdam_isqrt.sv */
// ============================================================================
// pdam_isqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module pdam_isqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [57:0]       n_in,
  input  pdam_pkg::qside_t  qs_in,
  output logic              out_vld,
  output logic [28:0]       root,
  output pdam_pkg::qside_t  qs_out
);
  import pdam_pkg::*;

  logic [57:0] n_r   [ISQRT_STEPS];
  logic [57:0] res_r [ISQRT_STEPS];
  qside_t      qs_r  [ISQRT_STEPS];
  logic        vld_r [ISQRT_STEPS];

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_st
    logic [57:0] n_prev, res_prev, bitv, trial;
    qside_t      qs_prev;
    logic        vld_prev;

    if (k == 0) begin : g_first
      assign n_prev   = n_in;
      assign res_prev = '0;
      assign qs_prev  = qs_in;
      assign vld_prev = in_vld;
    end else begin : g_next
      assign n_prev   = n_r[k-1];
      assign res_prev = res_r[k-1];
      assign qs_prev  = qs_r[k-1];
      assign vld_prev = vld_r[k-1];
    end

    assign bitv  = 58'd1 << (56 - 2 * k);
    assign trial = res_prev + bitv;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_prev >= trial) begin
          n_r[k]   <= n_prev - trial;
          res_r[k] <= (res_prev >> 1) + bitv;
        end else begin
          n_r[k]   <= n_prev;
          res_r[k] <= res_prev >> 1;
        end
        qs_r[k] <= qs_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_prev;
      end
    end
  end

  assign out_vld = vld_r[ISQRT_STEPS-1];
  assign root    = res_r[ISQRT_STEPS-1][28:0];
  assign qs_out  = qs_r[ISQRT_STEPS-1];

endmodule

/* rtl/pdam_cordic.sv */
// ============================================================================
// pdam_cordic
// Two-lane pipelined CORDIC atan2 (roll and pitch), Q3.13 results.
// ============================================================================
module pdam_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [pdam_pkg::CW-1:0] x_in [2],
  input  logic signed [pdam_pkg::CW-1:0] y_in [2],
  input  pdam_pkg::aside_t              as_in,
  output logic                          out_vld,
  output logic signed [15:0]            angle [2],
  output pdam_pkg::aside_t              as_out
);
  import pdam_pkg::*;

  localparam int NST = CORDIC_STEPS + 2;

  logic signed [CW-1:0] x_r [CORDIC_STEPS+1][2];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1][2];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS+1][2];
  logic signed [15:0]   angle_r [2];
  aside_t               as_r  [NST];
  logic                 vld_r [NST];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    // Fold the left half plane onto the right one.
    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in[l] < 0) begin
          x_r[0][l] <= -x_in[l];
          y_r[0][l] <= -y_in[l];
          z_r[0][l] <= (y_in[l] >= 0) ? PI_Q24 : -PI_Q24;
        end else begin
          x_r[0][l] <= x_in[l];
          y_r[0][l] <= y_in[l];
          z_r[0][l] <= '0;
        end
      end
    end

    // Once y reaches zero every later step leaves the vector alone.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CW-1:0] xs, ys;
      logic signed [ZW-1:0] t;
      assign xs = x_r[i][l] >>> i;
      assign ys = y_r[i][l] >>> i;
      assign t  = $signed({{(ZW-24){1'b0}}, ATAN_TAB[i]});

      always_ff @(posedge clk) begin
        if (en) begin
          if (y_r[i][l] > 0) begin
            x_r[i+1][l] <= x_r[i][l] + ys;
            y_r[i+1][l] <= y_r[i][l] - xs;
            z_r[i+1][l] <= z_r[i][l] + t;
          end else if (y_r[i][l] < 0) begin
            x_r[i+1][l] <= x_r[i][l] - ys;
            y_r[i+1][l] <= y_r[i][l] + xs;
            z_r[i+1][l] <= z_r[i][l] - t;
          end else begin
            x_r[i+1][l] <= x_r[i][l];
            y_r[i+1][l] <= y_r[i][l];
            z_r[i+1][l] <= z_r[i][l];
          end
        end
      end
    end

    // Round Q.24 to Q3.13 and saturate to 16 bits.
    logic signed [ZW-1:0] zr, zs;
    assign zr = z_r[CORDIC_STEPS][l] + 28'sd1024;
    assign zs = zr >>> 11;

    always_ff @(posedge clk) begin
      if (en) begin
        if (zs > 28'sd32767) begin
          angle_r[l] <= 16'sh7FFF;
        end else if (zs < -28'sd32768) begin
          angle_r[l] <= 16'sh8000;
        end else begin
          angle_r[l] <= zs[15:0];
        end
      end
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_side
    aside_t as_prev;
    logic   vld_prev;
    if (s == 0) begin : g_first
      assign as_prev  = as_in;
      assign vld_prev = in_vld;
    end else begin : g_next
      assign as_prev  = as_r[s-1];
      assign vld_prev = vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        as_r[s] <= as_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_prev;
      end
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign angle[0] = angle_r[0];
  assign angle[1] = angle_r[1];
  assign as_out   = as_r[NST-1];

endmodule

/* rtl/pdam_mixer.sv */
// ============================================================================
// pdam_mixer
// PD roll and pitch commands and the X mixer with rounding and clamping.
// ============================================================================
module pdam_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  pdam_pkg::aside_t   as_in,
  input  pdam_pkg::gains_t   gains,
  output logic               out_vld,
  output logic [63:0]        ts_out,
  output logic               armed_out,
  output logic signed [15:0] servo_a,
  output logic signed [15:0] servo_b,
  output logic signed [15:0] servo_c,
  output logic signed [15:0] servo_d
);
  import pdam_pkg::*;

  function automatic logic signed [15:0] clamp_mix(input logic signed [36:0] m,
                                                   input logic signed [16:0] lim);
    logic signed [36:0] t;
    logic signed [29:0] r;
    logic signed [29:0] l;
    t = m + 37'sd64;
    r = 30'(t >>> 7);
    l = 30'(lim);
    if (r > l) begin
      r = l;
    end else if (r < -l) begin
      r = -l;
    end
    return r[15:0];
  endfunction

  logic               vld_r [3];
  logic signed [31:0] pr_r, pp_r, dr_r, dp_r;
  logic signed [35:0] rc_r, pc_r;
  logic [63:0]        ts_a_r, ts_b_r, ts_c_r;
  logic               armed_a_r, armed_b_r, armed_c_r;
  logic signed [15:0] sa_r, sb_r, sc_r, sd_r;

  logic signed [15:0] rsel, psel;
  logic signed [16:0] lim17;

  always_comb begin
    rsel = as_in.sd.est ? roll : 16'sd0;
    priority if (!as_in.sd.est) begin
      psel = 16'sd0;
    end else if (as_in.sat_p) begin
      psel = HALF_PI_Q13;
    end else if (as_in.sat_n) begin
      psel = -HALF_PI_Q13;
    end else begin
      psel = pitch;
    end
    lim17 = {1'b0, gains.lim};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r      <= gains.roll_gain * rsel;
      pp_r      <= gains.pitch_gain * psel;
      dr_r      <= gains.rate_gain * as_in.sd.gx;
      dp_r      <= gains.rate_gain * as_in.sd.gy;
      ts_a_r    <= as_in.sd.ts;
      armed_a_r <= as_in.sd.armed;

      rc_r      <= -36'(pr_r) - (36'(dr_r) <<< 2);
      pc_r      <= -36'(pp_r) - (36'(dp_r) <<< 2);
      ts_b_r    <= ts_a_r;
      armed_b_r <= armed_a_r;

      sa_r      <= clamp_mix(37'(rc_r) - 37'(pc_r), lim17);
      sb_r      <= clamp_mix(-37'(rc_r) - 37'(pc_r), lim17);
      sc_r      <= clamp_mix(37'(rc_r) + 37'(pc_r), lim17);
      sd_r      <= clamp_mix(-37'(rc_r) + 37'(pc_r), lim17);
      ts_c_r    <= ts_b_r;
      armed_c_r <= armed_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '{default: 1'b0};
    end else if (en) begin
      vld_r[0] <= in_vld;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  assign out_vld   = vld_r[2];
  assign ts_out    = ts_c_r;
  assign armed_out = armed_c_r;
  assign servo_a   = sa_r;
  assign servo_b   = sb_r;
  assign servo_c   = sc_r;
  assign servo_d   = sd_r;

endmodule

/* verif/pd_attitude_mixer_check.sv */
// ============================================================================
// pd_attitude_mixer_check
// Watches the channels of the attitude mixer, predicts every servo word from
// the accepted input words and the written gains, and compares field by field.
// ============================================================================
module pd_attitude_mixer_check (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [167:0] in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import pdam_pkg::*;

  typedef struct {
    logic [63:0]        ts;
    logic               armed;
    logic               cmd_valid;
    logic signed [15:0] servo [4];
  } command_t;

  command_t servo_q [$];
  longint gain_roll, gain_pitch, gain_rate, defl_limit;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC angle in Q3.13, accumulated in Q.24.
  function automatic longint angle_of(longint yv, longint xv);
    longint x, y, z, xs, ys, a;
    x = xv;
    y = yv;
    z = 0;
    if (xv < 0) begin
      x = -xv;
      y = -yv;
      z = (yv >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y == 0) break;
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end
    end
    a = (z + 1024) >>> 11;
    if (a > 32767) a = 32767;
    if (a < -32768) a = -32768;
    return a;
  endfunction

  function automatic logic signed [15:0] clamp_mix(longint v, longint lim);
    longint r;
    r = (v + 64) >>> 7;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  function automatic command_t mix_command(logic [167:0] d, logic est);
    command_t c;
    longint w, x, y, z, gx, gy, roll, pitch, sinr, cosr, sinp, rc, pc, lim;
    w  = longint'($signed(d[15:0]));
    x  = longint'($signed(d[31:16]));
    y  = longint'($signed(d[47:32]));
    z  = longint'($signed(d[63:48]));
    gx = longint'($signed(d[79:64]));
    gy = longint'($signed(d[95:80]));
    roll  = 0;
    pitch = 0;
    if (est) begin
      sinr = 2 * (w * x + y * z);
      cosr = (longint'(1) << 28) - 2 * (x * x + y * y);
      sinp = 2 * (w * y - z * x);
      roll = angle_of(sinr, cosr);
      if (sinp >= (longint'(1) << 28)) pitch = HALF_PI_Q13;
      else if (sinp <= -(longint'(1) << 28)) pitch = -longint'(HALF_PI_Q13);
      else pitch = angle_of(sinp,
                   longint'(int_sqrt((64'd1 << 56) - longint'(sinp * sinp))));
    end
    rc  = -(gain_roll * roll) - 4 * (gain_rate * gx);
    pc  = -(gain_pitch * pitch) - 4 * (gain_rate * gy);
    lim = (defl_limit < 0) ? 0 : defl_limit;
    c.ts        = d[160:97];
    c.armed     = d[96];
    c.cmd_valid = 1'b1;
    c.servo[0]  = clamp_mix(rc - pc, lim);
    c.servo[1]  = clamp_mix(-rc - pc, lim);
    c.servo[2]  = clamp_mix(rc + pc, lim);
    c.servo[3]  = clamp_mix(-rc + pc, lim);
    return c;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  assign pending = servo_q.size();

  always @(posedge clk) begin
    command_t e;
    logic signed [15:0] got;
    if (!rst_n) begin
      gain_roll  <= 0;
      gain_pitch <= 0;
      gain_rate  <= 0;
      defl_limit <= 16384;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROLL_GAIN:  gain_roll  <= longint'($signed(cfg_data));
          REG_PITCH_GAIN: gain_pitch <= longint'($signed(cfg_data));
          REG_RATE_GAIN:  gain_rate  <= longint'($signed(cfg_data));
          REG_DEFL_LIMIT: defl_limit <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) servo_q.push_back(mix_command(in_tdata, in_tuser[0]));
      if (out_tvalid && out_tready) begin
        if (servo_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: servo word with none expected", $realtime);
        end else begin
          e = servo_q.pop_front();
          checked++;
          if (out_tdata[63:0] !== e.ts)
            report_mismatch("timestamp", longint'(e.ts), longint'(out_tdata[63:0]));
          if (out_tdata[64] !== e.armed)
            report_mismatch("armed", e.armed, out_tdata[64]);
          if (out_tdata[65] !== e.cmd_valid)
            report_mismatch("command_valid", e.cmd_valid, out_tdata[65]);
          for (int k = 0; k < 4; k++) begin
            got = out_tdata[66 + 16 * k +: 16];
            if (got !== e.servo[k])
              report_mismatch($sformatf("servo %0d", k), e.servo[k], got);
          end
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    checked    = 0;
  end
endmodule

/* verif/pd_attitude_mixer_test.sv */
// ============================================================================
// pd_attitude_mixer_test
// Drives attitude words and gain writes into the mixer under random flow
// control and a long output hold-off; the checker judges every servo word.
// ============================================================================
module pd_attitude_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdam_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [15:0]  cfg_data;
  int           fail_count;
  int           pending;
  int           checked;

  // Flow control knobs, in percent of cycles spent idle.
  int send_idle_pct;
  int recv_idle_pct;
  // Cycles left in a forced output hold-off.
  int hold_off_left;
  int words_sent;
  int stall_cycles;

  pd_attitude_mixer uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pd_attitude_mixer_check checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .checked
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver either sits in a forced hold-off or takes words at random.
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_tready    <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a long run of cycles with no word moving on any channel means
  // the block has locked up.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are only written once the pipeline has drained completely;
  // the input is withdrawn first so the last word is not offered again.
  task automatic set_gains(logic [15:0] rg, logic [15:0] pg, logic [15:0] tg,
                           logic [15:0] lim);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    write_reg(REG_ROLL_GAIN, rg);
    write_reg(REG_PITCH_GAIN, pg);
    write_reg(REG_RATE_GAIN, tg);
    write_reg(REG_DEFL_LIMIT, lim);
  endtask

  // Offers one word, with random idle cycles in front of it; tvalid stays
  // high after acceptance so back-to-back words need no second assignment.
  task automatic send_word(logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                           logic [15:0] qz, logic est, logic [15:0] gx,
                           logic [15:0] gy, logic armed, logic [63:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, ts, armed, gy, gx, qz, qy, qx, qw};
    in_tuser  <= est;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  function automatic logic [15:0] rand_comp(int kind);
    case (kind)
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(23170) - 11585);
      default: return 16'($urandom_range(8192) - 4096);
    endcase
  endfunction

  task automatic send_random();
    int kind;
    kind = $urandom_range(9) < 3 ? 0 : ($urandom_range(1) ? 1 : 2);
    send_word(rand_comp(kind), rand_comp(kind), rand_comp(kind), rand_comp(kind),
              $urandom_range(9) != 0, 16'($urandom), 16'($urandom),
              1'($urandom), {$urandom, $urandom});
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_off_left = 0;
    words_sent    = 0;
    stall_cycles  = 0;
    send_idle_pct = 37;
    recv_idle_pct = 57;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with moderate gains so every term shows in the servos.
    set_gains(16'sd512, -16'sd384, 16'sd64, 16'sd16384);
    // Writes to unused indexes must leave the gains alone.
    write_reg(8'd255, 16'hFFFF);
    write_reg(8'd4, 16'h0000);
    send_word(16384, 0, 0, 0, 1, 0, 0, 0, 64'd0);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 16'h8000, 16'h8000, 1, '1);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 16'h7FFF, 16'h7FFF, 0, 64'd1);
    // Invalid estimate: only the rate terms act.
    send_word(16'h1234, 16'h4321, 16'h7000, 16'h0F0F, 0, 16'h0400, 16'hFC00, 1, 64'd2);
    // Pitch just short of and just past vertical, both signs.
    send_word(11585, 0, 11585, 0, 1, 0, 0, 0, 64'd3);
    send_word(11586, 0, 11586, 0, 1, 0, 0, 1, 64'd4);
    send_word(11586, 0, -16'sd11586, 0, 1, 0, 0, 0, 64'd5);
    send_word(11585, 0, -16'sd11585, 0, 1, 0, 0, 1, 64'd6);
    // Roll past ninety degrees makes the cosine negative, both sine signs.
    send_word(0, 16384, 0, 0, 1, 0, 0, 0, 64'd7);
    send_word(100, 16384, 0, 0, 1, 0, 0, 0, 64'd8);
    send_word(-16'sd100, 16384, 0, 0, 1, 0, 0, 0, 64'd9);
    // Degenerate angle of a zero vector.
    send_word(0, 8192, 8192, 0, 1, 0, 0, 0, 64'd10);
    send_word(0, 0, 0, 0, 1, 16'h8000, 16'h7FFF, 1, 64'd11);
    send_word(11585, 11585, 0, 0, 1, 16'h0001, 16'hFFFF, 0, 64'h8000_0000_0000_0000);

    // Random phases over several gain settings, extremes among them.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 37;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: set_gains(16'sd256, 16'sd256, 16'sd256, 16'sd16384);
        1: set_gains(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767);
        2: set_gains(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd1);
        3: set_gains(16'sd128, 16'sd64, -16'sd32, -16'sd32768);
        4: set_gains(16'sd700, 16'sd700, 16'sd20, 16'sd0);
        default: set_gains(16'($urandom), 16'($urandom), 16'($urandom_range(2047)),
                           16'($urandom_range(32767)));
      endcase
      for (int n = 0; n < 182; n++) begin
        // Hold the output off long enough for the pipeline to fill and push
        // back on the input.
        if ((ph == 1 || ph == 7) && n == 40) hold_off_left = 400;
        send_random();
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Sent %0d attitude words over ten gain settings, %0d servo words checked.",
             words_sent, checked);
    $display("Covered invalid estimates, vertical pitch, negative limits and back-pressure.");
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

/* pd_attitude_mixer.f */
rtl/pdam_pkg.sv
rtl/pdam_front.sv
rtl/pdam_isqrt.sv
rtl/pdam_cordic.sv
rtl/pdam_mixer.sv
rtl/pd_attitude_mixer.sv
verif/pd_attitude_mixer_check.sv
verif/pd_attitude_mixer_test.sv
